// ----- hw/rtl/futex_waiter_slot_table_assert.svh -----
// Assertion macros for the waiter slot table.
`ifndef FUTEX_WAITER_SLOT_TABLE_ASSERT_SVH
`define FUTEX_WAITER_SLOT_TABLE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FWST_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define FWST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/fwst_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package fwst_pkg;

    localparam int SLOTS      = 4;
    localparam int ADDR_BITS  = 48;
    localparam int SLOT_IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SLOT_CNT_W = $clog2(SLOTS + 1);

    localparam logic [1:0] MODE_ARM    = 2'd0;
    localparam logic [1:0] MODE_DISARM = 2'd1;
    localparam logic [1:0] MODE_WAKE   = 2'd2;
    localparam logic [1:0] MODE_CHECK  = 2'd3;

    typedef struct packed {
        logic [1:0]         mode;
        logic [47:0]        wait_address;
        logic [1:0]         slot_select;
        logic               slot_select_valid;
        logic signed [31:0] operand_value;
        logic signed [31:0] current_word;
    } req_t;

    typedef struct packed {
        logic [1:0] slot_granted;
        logic       status_flag;
        logic [2:0] wake_reply;
    } rsp_t;

endpackage

`default_nettype wire

// ----- hw/rtl/futex_waiter_slot_table.sv -----
// futex_waiter_slot_table: waiter slot table for futex-style wait and wake.
// Request channel (req_valid/req_ready/req) carries one operation per transfer:
// arm, disarm, wake or check. Every request yields exactly one response on the
// rsp_valid/rsp_ready/rsp channel, in request order.
// Arm, disarm and check go from request transfer through the result register
// to the response register. Wake walks the address memory one slot per cycle,
// reading and comparing, and scans k slots (1 to SLOTS); the scan stops early
// once the wanted count is reached. A non-positive count finishes as a short
// operation. The next request can transfer once the previous result has moved
// to the output register.
// One request is in flight at a time; req_ready is high while the engine is
// idle, also while a finished response still waits in the output register.
// Armed bits sit in flip-flops; addresses sit in a single-port-read memory
// that is written only by arm, so a scan never races a write.
// Reset clears all armed bits and the response valid flag; addresses need no
// clearing since only armed slots are ever compared.
// If the receiver stalls, the response holds and at most one more finished
// result waits internally; further requests are then held off.
`timescale 1ns / 1ps
`default_nettype none

module futex_waiter_slot_table (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_ready,
    input  wire fwst_pkg::req_t req,
    output logic                rsp_valid,
    input  wire logic           rsp_ready,
    output fwst_pkg::rsp_t      rsp
);
    import fwst_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_WAKE   = 3'b010,
        S_RESULT = 3'b100
    } state_t;

    state_t                state_reg, state_next;
    logic [SLOTS-1:0]      armed_reg, armed_next;
    logic [SLOT_IDX_W-1:0] idx_reg, idx_next;
    logic [SLOT_CNT_W-1:0] woke_reg, woke_next;
    logic [ADDR_BITS-1:0]  addr_reg, addr_next;
    logic signed [31:0]    count_reg, count_next;
    rsp_t                  res_reg, res_next;
    rsp_t                  rsp_reg, rsp_next;
    logic                  rsp_valid_reg, rsp_valid_next;

    logic                  req_xfer;
    logic                  free_found;
    logic [SLOT_IDX_W-1:0] free_idx;
    logic                  sel_ok;
    logic [SLOT_IDX_W-1:0] sel_idx;
    logic                  differs;
    logic                  mem_we;
    logic [SLOT_IDX_W-1:0] mem_raddr;
    logic [ADDR_BITS-1:0]  mem_rdata;
    logic                  hit;
    logic [SLOT_CNT_W-1:0] woke_inc;
    logic                  scan_done;
    logic                  out_free;

    assign req_ready = (state_reg == S_IDLE);
    assign req_xfer  = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign out_free  = !rsp_valid_reg || rsp_ready;

    // lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!armed_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = SLOT_IDX_W'(i);
            end
        end
    end

    assign sel_ok  = req.slot_select_valid && (int'(req.slot_select) < SLOTS);
    assign sel_idx = SLOT_IDX_W'(req.slot_select);
    assign differs = req.current_word != req.operand_value;

    assign mem_we    = req_xfer && (req.mode == MODE_ARM) && free_found;
    assign mem_raddr = (state_reg == S_WAKE) ? idx_reg + 1'b1 : '0;

    fwst_addr_mem u_addr_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (free_idx),
        .wr_data (req.wait_address[ADDR_BITS-1:0]),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    // read data belongs to the slot at idx_reg
    assign hit       = armed_reg[idx_reg] && (mem_rdata == addr_reg);
    assign woke_inc  = woke_reg + SLOT_CNT_W'(hit);
    assign scan_done = (int'(idx_reg) == SLOTS - 1)
                    || (32'(woke_inc) >= $unsigned(count_reg));

    always_comb
    begin
        state_next     = state_reg;
        armed_next     = armed_reg;
        idx_next       = idx_reg;
        woke_next      = woke_reg;
        addr_next      = addr_reg;
        count_next     = count_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_xfer)
                begin
                    res_next   = '0;
                    state_next = S_RESULT;
                    unique case (req.mode)
                        MODE_ARM:
                        begin
                            if (free_found)
                            begin
                                armed_next[free_idx]  = 1'b1;
                                res_next.slot_granted = 2'(free_idx);
                                res_next.status_flag  = 1'b1;
                            end
                        end
                        MODE_DISARM:
                        begin
                            if (sel_ok)
                            begin
                                armed_next[sel_idx] = 1'b0;
                            end
                        end
                        MODE_WAKE:
                        begin
                            if (req.operand_value > 0)
                            begin
                                idx_next   = '0;
                                woke_next  = '0;
                                addr_next  = req.wait_address[ADDR_BITS-1:0];
                                count_next = req.operand_value;
                                state_next = S_WAKE;
                            end
                        end
                        MODE_CHECK:
                        begin
                            res_next.status_flag = sel_ok ? (!armed_reg[sel_idx] || differs)
                                                          : differs;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_WAKE:
            begin
                if (hit)
                begin
                    armed_next[idx_reg] = 1'b0;
                end
                woke_next = woke_inc;
                idx_next  = idx_reg + 1'b1;
                if (scan_done)
                begin
                    if (woke_inc == '0)
                    begin
                        res_next.wake_reply = 3'd1;
                    end
                    else if (32'(woke_inc) > 32'd7)
                    begin
                        res_next.wake_reply = 3'd7;
                    end
                    else
                    begin
                        res_next.wake_reply = 3'(woke_inc);
                    end
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            armed_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            armed_reg     <= armed_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        woke_reg  <= woke_next;
        addr_reg  <= addr_next;
        count_reg <= count_next;
        res_reg   <= res_next;
        rsp_reg   <= rsp_next;
    end

`include "futex_waiter_slot_table_assert.svh"

    `FWST_ASSERT_NOW(a_reply_bound, rsp_valid, (32'(rsp.wake_reply) <= ((SLOTS > 7) ? 7 : SLOTS)), "wake reply exceeds slot count")
    `FWST_ASSERT_NOW(a_woke_bound, (state_reg == S_WAKE), (32'(woke_reg) <= 32'(idx_reg)), "wake count ahead of scan index")
    `FWST_ASSERT_NEXT(a_arm_sets, (mem_we), (armed_reg[$past(free_idx)] && (state_reg == S_RESULT)), "armed slot not marked")

endmodule

`default_nettype wire

// ----- hw/rtl/fwst_addr_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Slot address store: one write port, one read port, registered read data.
module fwst_addr_mem (
    input  wire logic                             clk,
    input  wire logic                             wr_en,
    input  wire logic [fwst_pkg::SLOT_IDX_W-1:0]  wr_addr,
    input  wire logic [fwst_pkg::ADDR_BITS-1:0]   wr_data,
    input  wire logic [fwst_pkg::SLOT_IDX_W-1:0]  rd_addr,
    output logic      [fwst_pkg::ADDR_BITS-1:0]   rd_data
);
    import fwst_pkg::*;

    logic [ADDR_BITS-1:0] mem [SLOTS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    import fwst_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 20;
    localparam int RANDOM_ITEMS = 530;

    typedef enum logic [1:0] {STIM_REQ, STIM_PHASE, STIM_HOLD, STIM_DRAIN} stim_kind_t;

    typedef struct {
        stim_kind_t  kind;
        int unsigned phase;
        req_t        r;
    } stim_t;

    // idle percentages per phase: sender, receiver
    localparam int TX_IDLE [3] = '{8, 58, 0};
    localparam int RX_IDLE [3] = '{58, 8, 0};

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    stim_t pending[$];
    rsp_t  rsp_expected[$];
    rsp_t  rsp_head;

    // predicted table contents
    bit          waiter_armed [SLOTS];
    logic [47:0] waiter_addr [SLOTS];

    int unsigned req_count = 0;
    int unsigned rsp_count = 0;
    int unsigned idle_phase = 0;
    int unsigned hold_left = 0;
    int unsigned cycle_count = 0;
    int          mismatch_count = 0;
    bit          hold_start = 1'b0;
    bit          accepted;
    bit          stuck;
    bit          take_hold;
    int unsigned next_phase;

    futex_waiter_slot_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Apply one request to the predicted table and return the response it should produce.
    function automatic rsp_t table_apply(input req_t r);
        rsp_t o;
        int   woke;
        bit   sel_ok;
        bit   differs;
        bit   done;
        o = '0;
        woke = 0;
        done = 1'b0;
        sel_ok = r.slot_select_valid && (int'(r.slot_select) < SLOTS);
        case (r.mode)
            MODE_ARM:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!done && !waiter_armed[i])
                    begin
                        waiter_armed[i] = 1'b1;
                        waiter_addr[i] = r.wait_address;
                        o.slot_granted = i[1:0];
                        o.status_flag = 1'b1;
                        done = 1'b1;
                    end
                end
            end
            MODE_DISARM:
            begin
                if (sel_ok)
                begin
                    waiter_armed[r.slot_select] = 1'b0;
                    waiter_addr[r.slot_select] = '0;
                end
            end
            MODE_WAKE:
            begin
                if (r.operand_value > 0)
                begin
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (woke < r.operand_value && waiter_armed[i]
                            && waiter_addr[i] == r.wait_address)
                        begin
                            waiter_armed[i] = 1'b0;
                            waiter_addr[i] = '0;
                            woke++;
                        end
                    end
                    if (woke == 0)
                        o.wake_reply = 3'd1;
                    else
                        o.wake_reply = (woke > 7) ? 3'd7 : woke[2:0];
                end
            end
            default:
            begin
                differs = r.current_word != r.operand_value;
                if (sel_ok)
                    o.status_flag = !waiter_armed[r.slot_select] || differs;
                else
                    o.status_flag = differs;
            end
        endcase
        return o;
    endfunction

    function automatic req_t make_req(input logic [1:0] m, input logic [47:0] a,
                                      input logic [1:0] s, input logic sv,
                                      input logic signed [31:0] opd,
                                      input logic signed [31:0] w);
        req_t r;
        r.mode = m;
        r.wait_address = a;
        r.slot_select = s;
        r.slot_select_valid = sv;
        r.operand_value = opd;
        r.current_word = w;
        return r;
    endfunction

    task automatic push_req(input req_t r);
        stim_t s;
        s.kind = STIM_REQ;
        s.phase = 0;
        s.r = r;
        pending.push_back(s);
    endtask

    task automatic push_marker(input stim_kind_t k, input int unsigned ph);
        stim_t s;
        s.kind = k;
        s.phase = ph;
        s.r = '0;
        pending.push_back(s);
    endtask

    // Sender: one transfer per handshake, markers steer idling, hold-offs and drains.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
            req_count <= 0;
            hold_start <= 1'b0;
            idle_phase <= 0;
        end
        else
        begin
            accepted = req_valid && req_ready;
            take_hold = 1'b0;
            next_phase = idle_phase;
            if (accepted)
            begin
                rsp_expected.push_back(table_apply(req));
                req_count <= req_count + 1;
            end
            if (!req_valid || accepted)
            begin
                stuck = 1'b0;
                while (!stuck && pending.size() > 0 && pending[0].kind != STIM_REQ)
                begin
                    case (pending[0].kind)
                        STIM_PHASE:
                        begin
                            next_phase = pending[0].phase;
                            void'(pending.pop_front());
                        end
                        STIM_HOLD:
                        begin
                            take_hold = 1'b1;
                            void'(pending.pop_front());
                        end
                        default:
                        begin
                            if (!accepted && req_count == rsp_count)
                                void'(pending.pop_front());
                            else
                                stuck = 1'b1;
                        end
                    endcase
                end
                if (!stuck && pending.size() > 0
                    && $urandom_range(99) >= TX_IDLE[next_phase])
                begin
                    req_valid <= 1'b1;
                    req <= pending[0].r;
                    void'(pending.pop_front());
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
            hold_start <= take_hold;
            idle_phase <= next_phase;
        end
    end

    // Long receiver hold-off, counted here so the sender keeps pushing meanwhile.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_start)
            hold_left <= HOLD_CYCLES;
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // Receiver and response check.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            rsp_count <= 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                rsp_count <= rsp_count + 1;
                if (rsp_expected.size() == 0)
                begin
                    $display("%0t: response with nothing pending: granted=%0d status=%0d wake=%0d",
                             $time, rsp.slot_granted, rsp.status_flag, rsp.wake_reply);
                    mismatch_count++;
                end
                else
                begin
                    rsp_head = rsp_expected.pop_front();
                    if (rsp !== rsp_head)
                    begin
                        $display("%0t: mismatch expected granted=%0d status=%0d wake=%0d",
                                 $time, rsp_head.slot_granted, rsp_head.status_flag,
                                 rsp_head.wake_reply);
                        $display("%0t:          actual   granted=%0d status=%0d wake=%0d",
                                 $time, rsp.slot_granted, rsp.status_flag, rsp.wake_reply);
                        mismatch_count++;
                    end
                end
            end
            rsp_ready <= (hold_left == 0) && ($urandom_range(99) >= RX_IDLE[idle_phase]);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        logic [47:0]        addr_pool [4];
        logic [47:0]        a_near;
        logic [47:0]        a_far;
        logic [1:0]         m;
        logic [47:0]        a;
        logic signed [31:0] opd;
        logic signed [31:0] w;
        int unsigned        roll;

        for (int i = 0; i < SLOTS; i++)
        begin
            waiter_armed[i] = 1'b0;
            waiter_addr[i] = '0;
        end

        a_near = 48'h0000_1234_5678;
        a_far = 48'hABCD_0000_0040;

        // directed: fill, full table, check and wake corner cases, disarm paths
        push_req(make_req(MODE_ARM, 48'h0, 2'd0, 1'b0, 32'sd0, 32'sd0));
        push_req(make_req(MODE_ARM, 48'hFFFF_FFFF_FFFF, 2'd3, 1'b1, -32'sd1, -32'sd1));
        push_req(make_req(MODE_ARM, a_near, 2'd0, 1'b0, 32'sd0, 32'sd0));
        push_req(make_req(MODE_ARM, a_near, 2'd0, 1'b0, 32'sd0, 32'sd0));
        push_req(make_req(MODE_ARM, a_far, 2'd0, 1'b0, 32'sd0, 32'sd0));
        push_req(make_req(MODE_CHECK, 48'h0, 2'd0, 1'b1, 32'sd5, 32'sd5));
        push_req(make_req(MODE_CHECK, 48'h0, 2'd0, 1'b1, 32'sh8000_0000, 32'sh7FFF_FFFF));
        push_req(make_req(MODE_CHECK, 48'h0, 2'd3, 1'b0, -32'sd1, -32'sd1));
        push_req(make_req(MODE_CHECK, 48'h0, 2'd0, 1'b0, 32'sd0, 32'sd1));
        push_req(make_req(MODE_WAKE, a_near, 2'd0, 1'b0, 32'sd0, 32'sd0));
        push_req(make_req(MODE_WAKE, a_near, 2'd0, 1'b0, 32'sh8000_0000, 32'sd0));
        push_req(make_req(MODE_WAKE, a_near, 2'd0, 1'b0, 32'sd1, 32'sd0));
        push_req(make_req(MODE_WAKE, a_far, 2'd0, 1'b0, 32'sh7FFF_FFFF, 32'sd0));
        push_req(make_req(MODE_CHECK, 48'h0, 2'd2, 1'b1, 32'sd7, 32'sd7));
        push_req(make_req(MODE_DISARM, 48'h0, 2'd1, 1'b0, 32'sd0, 32'sd0));
        push_req(make_req(MODE_DISARM, 48'h0, 2'd2, 1'b1, 32'sd0, 32'sd0));
        push_req(make_req(MODE_DISARM, 48'h0, 2'd0, 1'b1, 32'sd0, 32'sd0));
        push_req(make_req(MODE_ARM, a_far, 2'd0, 1'b0, 32'sd0, 32'sd0));
        push_req(make_req(MODE_ARM, a_far, 2'd0, 1'b0, 32'sd0, 32'sd0));
        push_req(make_req(MODE_WAKE, a_far, 2'd0, 1'b0, 32'sh7FFF_FFFF, 32'sd0));
        push_req(make_req(MODE_WAKE, 48'hFFFF_FFFF_FFFF, 2'd0, 1'b0, 32'sd2, 32'sd0));
        push_req(make_req(MODE_WAKE, a_near, 2'd0, 1'b0, 32'sd3, 32'sd0));
        push_req(make_req(MODE_CHECK, 48'h0, 2'd3, 1'b1, -32'sd1, -32'sd1));
        push_marker(STIM_DRAIN, 0);

        addr_pool[0] = 48'({$urandom, $urandom});
        addr_pool[1] = 48'({$urandom, $urandom});
        addr_pool[2] = 48'h0;
        addr_pool[3] = 48'hFFFF_FFFF_FFFF;

        // random: a few shared addresses so wakes find matches, the odd stray one
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            case (i)
                60, 250, 420: push_marker(STIM_HOLD, 0);
                120, 300:     push_marker(STIM_DRAIN, 0);
                177:          push_marker(STIM_PHASE, 1);
                354:          push_marker(STIM_PHASE, 2);
                default:      ;
            endcase
            roll = $urandom_range(99);
            if (roll < 35)
                m = MODE_ARM;
            else if (roll < 55)
                m = MODE_DISARM;
            else if (roll < 80)
                m = MODE_WAKE;
            else
                m = MODE_CHECK;
            if ($urandom_range(99) < 85)
                a = addr_pool[$urandom_range(3)];
            else
                a = 48'({$urandom, $urandom});
            w = $urandom;
            opd = $urandom;
            if (m == MODE_WAKE)
            begin
                roll = $urandom_range(99);
                if (roll < 70)
                    opd = $urandom_range(5, 1);
                else if (roll < 80)
                    opd = 32'sd0;
                else if (roll < 90)
                    opd = {1'b1, 31'($urandom)};
            end
            else if (m == MODE_CHECK && $urandom_range(1) == 1)
            begin
                opd = w;
            end
            push_req(make_req(m, a, 2'($urandom_range(3)), $urandom_range(9) != 0, opd, w));
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // sample between edges so every update of the edge has settled
        while (pending.size() != 0 || req_valid || req_count != rsp_count)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (rsp_expected.size() != 0)
        begin
            $display("%0t: %0d responses never arrived", $time, rsp_expected.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
